@@ rtl/core/imu_motion_activity_detector_assert.svh @@
// Assertion macros used by the motion activity detector RTL.
`ifndef IMU_MOTION_ACTIVITY_DETECTOR_ASSERT_SVH
`define IMU_MOTION_ACTIVITY_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMAD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("imad assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("imad assertion failed");

`endif

@@ rtl/core/imad_pkg.sv @@
// Types, constants and helpers for the motion activity detector.
package imad_pkg;

  localparam int AXIS_BITS = 16;
  localparam int SUM_W     = 2 * AXIS_BITS + 2;
  localparam int ROOT_W    = AXIS_BITS + 1;
  localparam int PROD_W    = 2 * AXIS_BITS;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CNT_W     = $clog2(ROOT_W);
  localparam int CHG_W     = 16;
  localparam int CMP_W     = (ROOT_W > CHG_W) ? ROOT_W : CHG_W;
  localparam int LVL_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int N_AXES    = 6;

  localparam logic [CFG_W-1:0] ACC_THR_RST = CFG_W'(500);
  localparam logic [CFG_W-1:0] ROT_THR_RST = CFG_W'(1000);
  localparam logic [LVL_W-1:0] LEVEL_RST   = '0;
  localparam logic [1:0]       SMP_SAT     = 2'd2;
  localparam logic [CHG_W-1:0] CHG_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACC_THR = 2'd0,
    CFG_ROT_THR = 2'd1,
    CFG_LEVEL   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_UPDATE
  } state_e;

  // Magnitude of a two's complement axis value; the most negative value maps to 2^(N-1).
  function automatic logic [AXIS_BITS-1:0] abs_mag(input logic [AXIS_BITS-1:0] v);
    abs_mag = v[AXIS_BITS-1] ? (~v + AXIS_BITS'(1)) : v;
  endfunction

endpackage

@@ rtl/core/imu_motion_activity_detector.sv @@
// Motion activity detector top level: serial magnitude engine and window state.
// Each accepted sample passes through bit-serial shift-add squaring of all six
// axes in parallel, a step to sum the squares, AXIS_BITS+1 digit-by-digit
// square-root steps (two roots side by side) and a step to update the window
// before the block can take the next one. in_stall_o stays high while a sample
// is in flight. A report is emitted only for a sample marked window_end; it sits
// in an output register, and the next sample is accepted while it waits. A later
// sample that also closes a window holds in its update step until that report
// has been taken.
`include "imu_motion_activity_detector_assert.svh"

module imu_motion_activity_detector
  import imad_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [AXIS_BITS-1:0] acc_x_i,
  input  logic [AXIS_BITS-1:0] acc_y_i,
  input  logic [AXIS_BITS-1:0] acc_z_i,
  input  logic [AXIS_BITS-1:0] rot_x_i,
  input  logic [AXIS_BITS-1:0] rot_y_i,
  input  logic [AXIS_BITS-1:0] rot_z_i,
  input  logic                 window_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 activity_o,
  output logic [CHG_W-1:0]     acc_change_o,
  output logic [CHG_W-1:0]     rot_change_o,
  output logic [LVL_W-1:0]     level_out_o,
  output logic [CFG_W-1:0]     acc_limit_out_o,
  output logic [CFG_W-1:0]     rot_limit_out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [AXIS_BITS-1:0] mcand_q  [N_AXES];
  logic [AXIS_BITS-1:0] mplier_q [N_AXES];
  logic [PROD_W-1:0]    prod_q   [N_AXES];
  logic [AXIS_BITS-1:0] mcand_d  [N_AXES];
  logic [AXIS_BITS-1:0] mplier_d [N_AXES];
  logic [PROD_W-1:0]    prod_d   [N_AXES];
  logic [AXIS_BITS-1:0] axis_in  [N_AXES];

  logic [SUM_W-1:0]  rad_q  [2];
  logic [REM_W-1:0]  rem_q  [2];
  logic [ROOT_W-1:0] root_q [2];
  logic [SUM_W-1:0]  rad_d  [2];
  logic [REM_W-1:0]  rem_d  [2];
  logic [ROOT_W-1:0] root_d [2];

  logic wend_q;

  logic [1:0]        smp_cnt_q, smp_cnt_d;
  logic [ROOT_W-1:0] prev_acc_q, prev_acc_d;
  logic [ROOT_W-1:0] prev_rot_q, prev_rot_d;
  logic              act_flag_q, act_flag_d;
  logic [CHG_W-1:0]  last_acc_q, last_acc_d;
  logic [CHG_W-1:0]  last_rot_q, last_rot_d;

  logic [CFG_W-1:0] acc_thr_q, rot_thr_q;
  logic [LVL_W-1:0] level_q;

  logic              out_valid_q, out_valid_d;
  logic              out_act_q;
  logic [CHG_W-1:0]  out_acc_chg_q, out_rot_chg_q;
  logic [LVL_W-1:0]  out_level_q;
  logic [CFG_W-1:0]  out_acc_lim_q, out_rot_lim_q;

  logic in_acc, do_load, do_square, do_sum, do_root, do_update, do_report;
  logic out_blocked;

  logic [ROOT_W-1:0] da, dr;
  logic [CMP_W-1:0]  da_w, dr_w;
  logic [CHG_W-1:0]  da_sat, dr_sat;
  logic              hit;

  logic              rep_act;
  logic [CHG_W-1:0]  rep_acc, rep_rot;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_blocked = out_valid_q && out_stall_i;

  assign axis_in[0] = acc_x_i;
  assign axis_in[1] = acc_y_i;
  assign axis_in[2] = acc_z_i;
  assign axis_in[3] = rot_x_i;
  assign axis_in[4] = rot_y_i;
  assign axis_in[5] = rot_z_i;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    do_load    = 1'b0;
    do_square  = 1'b0;
    do_sum     = 1'b0;
    do_root    = 1'b0;
    do_update  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          do_load = 1'b1;
          cnt_d   = '0;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        do_square = 1'b1;
        if (cnt_q == CNT_W'(AXIS_BITS - 1)) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SUM: begin
        do_sum  = 1'b1;
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        do_root = 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          state_d = ST_UPDATE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        // hold while a report is still waiting and this sample closes a window
        if (!(wend_q && out_blocked)) begin
          do_update = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign do_report = do_update && wend_q;

  // Bit-serial squaring, MSB of the multiplier first
  always_comb begin
    for (int k = 0; k < N_AXES; k++) begin
      mcand_d[k]  = mcand_q[k];
      mplier_d[k] = mplier_q[k];
      prod_d[k]   = prod_q[k];
      if (do_load) begin
        mcand_d[k]  = abs_mag(axis_in[k]);
        mplier_d[k] = abs_mag(axis_in[k]);
        prod_d[k]   = '0;
      end else if (do_square) begin
        mplier_d[k] = {mplier_q[k][AXIS_BITS-2:0], 1'b0};
        prod_d[k]   = {prod_q[k][PROD_W-2:0], 1'b0}
                      + (mplier_q[k][AXIS_BITS-1] ? PROD_W'(mcand_q[k]) : '0);
      end
    end
  end

  // Digit-by-digit square root, two radicand bits per step
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    for (int v = 0; v < 2; v++) begin
      rad_d[v]  = rad_q[v];
      rem_d[v]  = rem_q[v];
      root_d[v] = root_q[v];
      rem_sh    = {rem_q[v][REM_W-3:0], rad_q[v][SUM_W-1:SUM_W-2]};
      trial     = {root_q[v], 2'b01};
      if (do_sum) begin
        rad_d[v]  = SUM_W'(prod_q[3*v]) + SUM_W'(prod_q[3*v+1]) + SUM_W'(prod_q[3*v+2]);
        rem_d[v]  = '0;
        root_d[v] = '0;
      end else if (do_root) begin
        rad_d[v] = {rad_q[v][SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d[v]  = rem_sh - trial;
          root_d[v] = {root_q[v][ROOT_W-2:0], 1'b1};
        end else begin
          rem_d[v]  = rem_sh;
          root_d[v] = {root_q[v][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Window update
  always_comb begin
    da     = (root_q[0] >= prev_acc_q) ? (root_q[0] - prev_acc_q) : (prev_acc_q - root_q[0]);
    dr     = (root_q[1] >= prev_rot_q) ? (root_q[1] - prev_rot_q) : (prev_rot_q - root_q[1]);
    da_w   = CMP_W'(da);
    dr_w   = CMP_W'(dr);
    da_sat = (da_w > CMP_W'(CHG_MAX)) ? CHG_MAX : da_w[CHG_W-1:0];
    dr_sat = (dr_w > CMP_W'(CHG_MAX)) ? CHG_MAX : dr_w[CHG_W-1:0];
    hit    = (da_w > CMP_W'(acc_thr_q)) || (dr_w > CMP_W'(rot_thr_q));

    smp_cnt_d  = smp_cnt_q;
    prev_acc_d = prev_acc_q;
    prev_rot_d = prev_rot_q;
    act_flag_d = act_flag_q;
    last_acc_d = last_acc_q;
    last_rot_d = last_rot_q;
    if (do_update) begin
      if (smp_cnt_q == SMP_SAT) begin
        act_flag_d = act_flag_q || hit;
        last_acc_d = da_sat;
        last_rot_d = dr_sat;
      end else begin
        smp_cnt_d = smp_cnt_q + 2'd1;
      end
      prev_acc_d = root_q[0];
      prev_rot_d = root_q[1];
      // drop all window history once the report is issued
      if (wend_q) begin
        smp_cnt_d  = '0;
        prev_acc_d = '0;
        prev_rot_d = '0;
        act_flag_d = 1'b0;
        last_acc_d = '0;
        last_rot_d = '0;
      end
    end
  end

  // the report takes the window values before they are cleared
  always_comb begin
    if (smp_cnt_q == SMP_SAT) begin
      rep_act = act_flag_q || hit;
      rep_acc = da_sat;
      rep_rot = dr_sat;
    end else begin
      rep_act = act_flag_q;
      rep_acc = last_acc_q;
      rep_rot = last_rot_q;
    end
  end

  assign out_valid_d = out_blocked || do_report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      smp_cnt_q   <= '0;
      prev_acc_q  <= '0;
      prev_rot_q  <= '0;
      act_flag_q  <= 1'b0;
      last_acc_q  <= '0;
      last_rot_q  <= '0;
      acc_thr_q   <= ACC_THR_RST;
      rot_thr_q   <= ROT_THR_RST;
      level_q     <= LEVEL_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      smp_cnt_q   <= smp_cnt_d;
      prev_acc_q  <= prev_acc_d;
      prev_rot_q  <= prev_rot_d;
      act_flag_q  <= act_flag_d;
      last_acc_q  <= last_acc_d;
      last_rot_q  <= last_rot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACC_THR: acc_thr_q <= cfg_data_i;
          CFG_ROT_THR: rot_thr_q <= cfg_data_i;
          CFG_LEVEL:   level_q   <= cfg_data_i[LVL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N_AXES; k++) begin
      mcand_q[k]  <= mcand_d[k];
      mplier_q[k] <= mplier_d[k];
      prod_q[k]   <= prod_d[k];
    end
    for (int v = 0; v < 2; v++) begin
      rad_q[v]  <= rad_d[v];
      rem_q[v]  <= rem_d[v];
      root_q[v] <= root_d[v];
    end
    if (in_acc) begin
      wend_q <= window_end_i;
    end
    if (do_report) begin
      out_act_q     <= rep_act;
      out_acc_chg_q <= rep_acc;
      out_rot_chg_q <= rep_rot;
      out_level_q   <= level_q;
      out_acc_lim_q <= acc_thr_q;
      out_rot_lim_q <= rot_thr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign activity_o      = out_act_q;
  assign acc_change_o    = out_acc_chg_q;
  assign rot_change_o    = out_rot_chg_q;
  assign level_out_o     = out_level_q;
  assign acc_limit_out_o = out_acc_lim_q;
  assign rot_limit_out_o = out_rot_lim_q;

  `IMAD_ASSERT_NEXT(a_accept_starts_square, clk_i, rst_ni, in_acc, (state_q == ST_SQUARE) && (cnt_q == '0))
  `IMAD_ASSERT_IMPL(a_report_from_update, clk_i, rst_ni, $rose(out_valid_q), $past((state_q == ST_UPDATE) && wend_q))
  `IMAD_ASSERT_IMPL(a_flag_needs_history, clk_i, rst_ni, $rose(act_flag_q), $past(smp_cnt_q) == SMP_SAT)
  `IMAD_ASSERT_NEXT(a_window_cleared, clk_i, rst_ni, do_report, (smp_cnt_q == '0) && !act_flag_q)

endmodule
